// ----- src/gte_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Graph traversal engine package
// Shared types, constants and the controller/datapath command interface.
// ----------------------------------------------------------------------------
package gte_pkg;

   localparam int MaxVertices  = 32;
   localparam int VertexWidth  = 5;
   localparam int PendingDepth = 512;
   localparam int PendWidth    = 9;
   localparam int FillWidth    = 10;
   localparam int CountWidth   = 6;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_DFS = 2'd1;
   localparam logic [1:0] OP_BFS = 2'd2;

   typedef struct packed {
      logic [1:0]             op;
      logic [VertexWidth-1:0] vertex_a;
      logic [VertexWidth-1:0] vertex_b;
   } req_word_type;

   typedef struct packed {
      logic [VertexWidth-1:0] parent_vertex;
      logic [VertexWidth-1:0] child_vertex;
      logic                   has_edge;
      logic                   found;
      logic                   range_error;
      logic                   last;
   } rsp_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture request word
      logic add_edge;   // write both adjacency bits
      logic init;       // clear visited, pointers, mark start
      logic load_row;   // take adjacency row of current vertex into scan register
      logic push;       // push lowest set scan bit
      logic pop_take;   // consume popped entry
      logic emit_edge;
      logic emit_status;
      logic emit_add;
   } gte_cmd_type;

   // Status back to the controller.
   typedef struct packed {
      logic op_add;
      logic op_valid;
      logic range_bad;
      logic start_is_end;
      logic scan_empty;
      logic fill_empty;
      logic popped_visited;
      logic popped_is_end;
   } gte_sts_type;

endpackage
`default_nettype wire

// ----- src/graph_traversal_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Graph traversal engine
// Undirected adjacency bitmap with depth-first and breadth-first search.
// ----------------------------------------------------------------------------
// An add shows its single result word once the request word has been
// registered and decoded, and busy falls at the edge that ends that word. A
// search pushes one neighbour per cycle from the scan register and pops
// entries through the registered read of the pending store; a popped entry
// that is already visited goes back to the push step, and a newly visited
// vertex emits its edge word and, unless it is the end, has its row loaded.
// Result words are shown for one cycle under rsp_valid and cannot be stalled.
// busy stays high until the last word of a request has been shown.
module graph_traversal_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire gte_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   output gte_pkg::rsp_word_type      rsp_word,
   input  wire logic                  csr_write,
   input  wire logic [5:0]            csr_wdata
);
   import gte_pkg::*;

   gte_cmd_type cmd;
   gte_sts_type sts;

   gte_control u_control (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .sts      (sts),
      .cmd      (cmd)
   );

   gte_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .csr_write(csr_write),
      .csr_wdata(csr_wdata),
      .req_word (req_word),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_word (rsp_word)
   );
endmodule
`default_nettype wire

// ----- src/gte_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gte_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- src/gte_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Graph traversal datapath
// Adjacency bitmap, visited mask, neighbour scan and pending store.
// ----------------------------------------------------------------------------
module gte_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [5:0]            csr_wdata,
   input  wire gte_pkg::req_word_type req_word,
   input  wire gte_pkg::gte_cmd_type  cmd,
   output gte_pkg::gte_sts_type       sts,
   output gte_pkg::rsp_word_type      rsp_word
);
   import gte_pkg::*;

   logic [CountWidth-1:0]  count_ff;
   logic [MaxVertices-1:0] adj_ff [MaxVertices];
   logic [MaxVertices-1:0] visited_ff, scan_ff, mask;
   req_word_type           word_ff;
   logic [VertexWidth-1:0] cur_ff;
   logic [PendWidth-1:0]   rptr_ff, wptr_ff, rd_addr;
   logic [FillWidth-1:0]   fill_ff;
   logic [9:0]             rd_data;
   logic [VertexWidth-1:0] low_idx, pop_par, pop_chi;
   logic [CountWidth-1:0]  eff;
   logic                   a_bad, b_bad, is_dfs;

   assign eff   = (count_ff > CountWidth'(MaxVertices)) ? CountWidth'(MaxVertices) : count_ff;
   assign a_bad = {1'b0, word_ff.vertex_a} >= eff;
   assign b_bad = {1'b0, word_ff.vertex_b} >= eff;
   assign is_dfs = (word_ff.op == OP_DFS);

   // In-range mask for the effective vertex count.
   always_comb begin
      for (int i = 0; i < MaxVertices; i++) begin
         mask[i] = (CountWidth'(i) < eff);
      end
   end

   // Lowest set bit of the scan register.
   always_comb begin
      low_idx = '0;
      for (int i = MaxVertices - 1; i >= 0; i--) begin
         if (scan_ff[i]) begin
            low_idx = VertexWidth'(i);
         end
      end
   end

   assign pop_par = rd_data[9:5];
   assign pop_chi = rd_data[4:0];

   // Stack pops from the top, queue from the head.
   assign rd_addr = is_dfs ? (wptr_ff - 1'b1) : rptr_ff;

   gte_ram #(.Width(10), .Depth(PendingDepth)) u_pending (
      .clock  (clock),
      .wr_en  (cmd.push && (fill_ff < FillWidth'(PendingDepth))),
      .wr_addr(wptr_ff),
      .wr_data({cur_ff, low_idx}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountWidth'(MaxVertices);
      end else if (csr_write) begin
         count_ff <= csr_wdata;
      end
   end

   // Adjacency bitmap.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MaxVertices; i++) begin
            adj_ff[i] <= '0;
         end
      end else if (cmd.add_edge) begin
         adj_ff[word_ff.vertex_a][word_ff.vertex_b] <= 1'b1;
         adj_ff[word_ff.vertex_b][word_ff.vertex_a] <= 1'b1;
      end
   end

   // Search state.
   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
         rptr_ff    <= '0;
         wptr_ff    <= '0;
         fill_ff    <= '0;
      end else if (cmd.init) begin
         visited_ff <= MaxVertices'(1) << word_ff.vertex_a;
         rptr_ff    <= '0;
         wptr_ff    <= '0;
         fill_ff    <= '0;
      end else begin
         if (cmd.push && (fill_ff < FillWidth'(PendingDepth))) begin
            wptr_ff <= wptr_ff + 1'b1;
            fill_ff <= fill_ff + 1'b1;
         end
         if (cmd.pop_take) begin
            fill_ff <= fill_ff - 1'b1;
            if (is_dfs) begin
               wptr_ff <= wptr_ff - 1'b1;
            end else begin
               rptr_ff <= rptr_ff + 1'b1;
            end
            visited_ff[pop_chi] <= 1'b1;
         end
      end
   end

   // Request capture, current vertex and neighbour scan.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= req_word;
      end
      if (cmd.init) begin
         cur_ff <= word_ff.vertex_a;
      end else if (cmd.pop_take) begin
         cur_ff <= pop_chi;
      end
      if (cmd.load_row) begin
         scan_ff <= adj_ff[cur_ff] & mask & ~visited_ff;
      end else if (cmd.push) begin
         scan_ff[low_idx] <= 1'b0;
      end
   end

   // Result word.
   always_ff @(posedge clock) begin
      rsp_word <= '0;
      if (cmd.emit_edge) begin
         rsp_word.parent_vertex <= pop_par;
         rsp_word.child_vertex  <= pop_chi;
         rsp_word.has_edge      <= 1'b1;
      end else if (cmd.emit_add) begin
         rsp_word.range_error <= a_bad || b_bad;
         rsp_word.last        <= 1'b1;
      end else if (cmd.emit_status) begin
         rsp_word.range_error <= a_bad || b_bad;
         rsp_word.found       <= !(a_bad || b_bad) &&
                                 visited_ff[word_ff.vertex_b];
         rsp_word.last        <= 1'b1;
      end
   end

   assign sts.op_add         = (word_ff.op == OP_ADD);
   assign sts.op_valid       = (word_ff.op == OP_ADD) || is_dfs || (word_ff.op == OP_BFS);
   assign sts.range_bad      = a_bad || b_bad;
   assign sts.start_is_end   = (word_ff.vertex_a == word_ff.vertex_b);
   assign sts.scan_empty     = (scan_ff == '0);
   assign sts.fill_empty     = (fill_ff == '0);
   assign sts.popped_visited = visited_ff[pop_chi];
   assign sts.popped_is_end  = (pop_chi == word_ff.vertex_b);
endmodule
`default_nettype wire

// ----- src/gte_control.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Graph traversal controller
// Sequences add, scan, push and pop steps of one request.
// ----------------------------------------------------------------------------
module gte_control (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   output logic                     rsp_valid,
   input  wire gte_pkg::gte_sts_type sts,
   output gte_pkg::gte_cmd_type     cmd
);
   import gte_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DECODE = 9'b000000010,
      S_INIT   = 9'b000000100,
      S_ROW    = 9'b000001000,
      S_PUSH   = 9'b000010000,
      S_POPREQ = 9'b000100000,
      S_POP    = 9'b001000000,
      S_STATUS = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!sts.op_valid) begin
               state_in = S_IDLE;
            end else if (sts.op_add) begin
               cmd.add_edge = !sts.range_bad;
               cmd.emit_add = 1'b1;
               valid_in     = 1'b1;
               state_in     = S_DONE;
            end else if (sts.range_bad) begin
               state_in = S_STATUS;
            end else begin
               cmd.init = 1'b1;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            state_in = sts.start_is_end ? S_STATUS : S_ROW;
         end
         S_ROW: begin
            cmd.load_row = 1'b1;
            state_in     = S_PUSH;
         end
         S_PUSH: begin
            if (sts.scan_empty) begin
               state_in = sts.fill_empty ? S_STATUS : S_POPREQ;
            end else begin
               cmd.push = 1'b1;
            end
         end
         S_POPREQ: begin
            state_in = S_POP;
         end
         S_POP: begin
            cmd.pop_take = 1'b1;
            if (sts.popped_visited) begin
               state_in = S_PUSH;
            end else begin
               cmd.emit_edge = 1'b1;
               valid_in      = 1'b1;
               state_in      = sts.popped_is_end ? S_STATUS : S_ROW;
            end
         end
         S_STATUS: begin
            cmd.emit_status = 1'b1;
            valid_in        = 1'b1;
            state_in        = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and strobe registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
endmodule
`default_nettype wire
